@@ hw/rtl/srr_pkg.sv @@
// shared types, constants and helpers for the selective repeat receiver
package srr_pkg;

    localparam int BUFFER_DEPTH = 8;
    localparam int SEQ_BITS     = 16;
    localparam int SEQ_IN_W     = 16;
    localparam int VALUE_W      = 17;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    typedef logic [SEQ_BITS-1:0]       t_seq;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_value VALUE_NONE = '1;

    typedef enum logic [1:0] {
        K_DELIVER = 2'd0,
        K_CUM_ACK = 2'd1,
        K_BUF_ACK = 2'd2,
        K_REJECT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN,
        S_ACK
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    // input sequence field reduced to SEQ_BITS
    function automatic t_seq seq_from_in(input logic [SEQ_IN_W-1:0] x);
        logic [SEQ_BITS+SEQ_IN_W-1:0] w;
        w = {{SEQ_BITS{1'b0}}, x};
        return w[SEQ_BITS-1:0];
    endfunction

    // sequence number as result value, low VALUE_W bits
    function automatic t_value to_value(input t_seq s);
        logic [SEQ_BITS+VALUE_W-1:0] w;
        w = {{VALUE_W{1'b0}}, s};
        return w[VALUE_W-1:0];
    endfunction

endpackage

@@ hw/rtl/srr_in_if.sv @@
// arriving frame channel
interface srr_in_if;
    import srr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SEQ_IN_W-1:0] seq;
    logic                lost;

    modport source (output valid, output seq, output lost, input ready);
    modport sink   (input valid, input seq, input lost, output ready);
endinterface

@@ hw/rtl/srr_out_if.sv @@
// result channel
interface srr_out_if;
    import srr_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    t_value      value;
    logic        last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

@@ hw/rtl/srr_cell.sv @@
// one reorder buffer cell: holds a sequence number, shifts toward the head
module srr_cell (
    input  logic              i_clk,
    input  srr_pkg::t_cell_ctl i_ctl,
    input  srr_pkg::t_seq     i_new,
    input  srr_pkg::t_seq     i_next,
    input  srr_pkg::t_seq     i_probe,
    output srr_pkg::t_seq     o_entry,
    output logic              o_match
);
    import srr_pkg::*;

    t_seq r_entry;
    t_seq n_entry;

    always_comb begin
        priority if (i_ctl.load) begin
            n_entry = i_new;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_probe);
endmodule

@@ hw/rtl/selective_repeat_receiver.sv @@
// selective repeat receiver: one result per cycle unless the output stalls,
// frames taken one at a time; a lost, rejected or buffered frame gives one result,
// valid the next cycle; an in-order frame is delivered, then the reorder cell row
// shifts one entry per cycle if not stalled into the output, then the ack follows
// synchronous active-low reset clears the pointers, count and output valid;
// the cell contents are not reset
module selective_repeat_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srr_in_if.sink      i_frame,
    srr_out_if.source   o_result
);
    import srr_pkg::*;

    t_state r_state, n_state;
    t_seq   r_expected, n_expected;
    t_seq   r_ntb, n_ntb;
    t_value r_last_acked, n_last_acked;
    t_cnt   r_count, n_count;

    logic   r_out_valid, n_out_valid;
    t_kind  r_kind, n_kind;
    t_value r_value, n_value;
    logic   r_last, n_last;

    logic   can_emit;
    logic   accept;
    logic   dup;
    logic   do_append;
    logic   do_shift;
    logic   emit;
    t_kind  e_kind;
    t_value e_value;
    logic   e_last;
    t_seq   in_seq;

    t_seq                    w_entry [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] w_match;
    logic [BUFFER_DEPTH-1:0] w_in_use;
    t_cell_ctl               w_ctl   [BUFFER_DEPTH];

    assign can_emit = !r_out_valid || o_result.ready;
    assign accept   = i_frame.valid && i_frame.ready;
    assign in_seq   = seq_from_in(i_frame.seq);
    assign dup      = |(w_match & w_in_use);

    // reorder cell row, cell 0 is the head
    for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
        t_seq w_next;
        if (i < BUFFER_DEPTH - 1) begin : g_mid
            assign w_next = w_entry[i+1];
        end else begin : g_end
            assign w_next = w_entry[i];
        end
        assign w_in_use[i]    = (CNT_W'(i) < r_count);
        assign w_ctl[i].load  = do_append && (r_count == CNT_W'(i));
        assign w_ctl[i].shift = do_shift;

        srr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_new   (in_seq),
            .i_next  (w_next),
            .i_probe (in_seq),
            .o_entry (w_entry[i]),
            .o_match (w_match[i])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !i_frame.lost && in_seq == r_expected) begin
                    n_state = (r_count != '0) ? S_DRAIN : S_ACK;
                end
            end
            S_DRAIN: begin
                if (can_emit && r_count == t_cnt'(1)) begin
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        i_frame.ready = (r_state == S_IDLE) && can_emit;
        emit          = 1'b0;
        e_kind        = K_REJECT;
        e_value       = VALUE_NONE;
        e_last        = 1'b1;
        do_append     = 1'b0;
        do_shift      = 1'b0;
        n_expected    = r_expected;
        n_ntb         = r_ntb;
        n_last_acked  = r_last_acked;
        n_count       = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    emit = 1'b1;
                    if (i_frame.lost) begin
                        if (r_count == '0) begin
                            n_ntb = (in_seq == r_expected) ? in_seq + t_seq'(1) : in_seq;
                        end
                    end else if (in_seq != r_expected) begin
                        if (r_count != t_cnt'(BUFFER_DEPTH) && !dup && r_ntb == in_seq) begin
                            do_append = 1'b1;
                            n_count   = r_count + t_cnt'(1);
                            n_ntb     = in_seq + t_seq'(1);
                            e_kind    = K_BUF_ACK;
                            e_value   = r_last_acked;
                        end
                    end else begin
                        e_kind  = K_DELIVER;
                        e_value = to_value(in_seq);
                        e_last  = 1'b0;
                    end
                end
            end
            S_DRAIN: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    do_shift   = 1'b1;
                    e_kind     = K_DELIVER;
                    e_value    = to_value(w_entry[0]);
                    e_last     = 1'b0;
                    n_expected = w_entry[0];
                    n_count    = r_count - t_cnt'(1);
                end
            end
            S_ACK: begin
                if (can_emit) begin
                    emit         = 1'b1;
                    e_kind       = K_CUM_ACK;
                    e_value      = to_value(r_expected);
                    e_last       = 1'b1;
                    n_last_acked = to_value(r_expected);
                    n_expected   = r_expected + t_seq'(1);
                end
            end
            default: ;
        endcase

        n_out_valid = r_out_valid && !o_result.ready;
        n_kind      = r_kind;
        n_value     = r_value;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_kind      = e_kind;
            n_value     = e_value;
            n_last      = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_expected   <= '0;
            r_ntb        <= '0;
            r_last_acked <= VALUE_NONE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_expected   <= n_expected;
            r_ntb        <= n_ntb;
            r_last_acked <= n_last_acked;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
        r_last  <= n_last;
    end

    assign o_result.valid = r_out_valid;
    assign o_result.kind  = r_kind;
    assign o_result.value = r_value;
    assign o_result.last  = r_last;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(BUFFER_DEPTH))
        else $error("reorder count above depth");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.ready |-> r_state == S_IDLE)
        else $error("frame taken outside idle");

    a_lost_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_frame.lost) |=> (r_state == S_IDLE && $stable(r_count)))
        else $error("lost frame changed buffer");

    a_ack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACK |-> r_count == '0)
        else $error("ack with frames still buffered");

    a_cum_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == K_CUM_ACK) |-> r_last)
        else $error("cumulative ack not final");
`endif
endmodule

@@ test/selective_repeat_receiver_test.sv @@
// self-checking testbench for the selective repeat receiver: directed table, then random frames
`timescale 1ns / 1ps

module selective_repeat_receiver_test;
    import srr_pkg::*;

    localparam int RANDOM_FRAMES = 156;
    localparam int SETTLE_CYCLES = BUFFER_DEPTH + 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        t_kind  kind;
        t_value value;
        logic   last;
    } t_result;

    // known = 1: the single result of the row is typed in, else the predictor decides
    typedef struct packed {
        logic [SEQ_IN_W-1:0] seq;
        logic                lost;
        logic                known;
        t_kind               kind;
        t_value              value;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic [31:0] cycle_count = '0;

    srr_in_if  frame_if ();
    srr_out_if result_if ();

    selective_repeat_receiver u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if),
        .o_result (result_if)
    );

    // receiver-side copy of the window state
    t_seq   rx_expected;
    t_seq   rx_next_buf;
    t_value rx_last_ack;
    int     rx_count;
    t_seq   rx_store [BUFFER_DEPTH];

    t_result frame_results[$];
    t_result pending_results[$];

    int fail_count    = 0;
    int results_seen  = 0;
    int frames_sent   = 0;
    int lost_frames   = 0;
    int full_hits     = 0;
    int buffered_acks = 0;
    int longest_drain = 0;
    int burst_left    = 0;

    t_row directed_rows [DIRECTED_ROWS] = '{
        '{16'h0005, 1'b0, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'hFFFF, 1'b1, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'hFFFF, 1'b0, 1'b1, K_BUF_ACK, VALUE_NONE},
        '{16'hFFFF, 1'b0, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'h0000, 1'b0, 1'b0, K_DELIVER, VALUE_NONE},
        '{16'h0000, 1'b1, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'h0001, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h0002, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h0003, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h0004, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h0005, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h0006, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h0007, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h0008, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h0009, 1'b0, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'h0003, 1'b1, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'h0000, 1'b0, 1'b0, K_DELIVER, VALUE_NONE},
        '{16'h0009, 1'b0, 1'b0, K_DELIVER, VALUE_NONE},
        '{16'h0014, 1'b0, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'h8000, 1'b0, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'h000C, 1'b1, 1'b1, K_REJECT,  VALUE_NONE},
        '{16'h000C, 1'b0, 1'b0, K_BUF_ACK, VALUE_NONE},
        '{16'h000A, 1'b0, 1'b0, K_DELIVER, VALUE_NONE},
        '{16'h000E, 1'b0, 1'b1, K_REJECT,  VALUE_NONE}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("selective_repeat_receiver regression: fail");
            $finish;
        end
    end

    // result stalls: always ready, coin flip, one in four, mostly ready
    always @(posedge i_clk) begin
        case (cycle_count[8:7])
            2'd0: begin
                result_if.ready <= 1'b1;
            end
            2'd1: begin
                result_if.ready <= ($urandom_range(0, 1) == 1);
            end
            2'd2: begin
                result_if.ready <= (cycle_count[1:0] == 2'b11);
            end
            default: begin
                result_if.ready <= ($urandom_range(0, 9) != 0);
            end
        endcase
    end

    function automatic t_result make_result(input t_kind kind, input t_value value);
        t_result r;
        r.kind  = kind;
        r.value = value;
        r.last  = 1'b0;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // window update for one accepted frame, results land in frame_results
    task automatic predict_frame(input t_seq s, input logic lost);
        bit dup;
        dup = 1'b0;
        frame_results.delete();
        if (lost) begin
            frame_results.push_back(make_result(K_REJECT, VALUE_NONE));
            // re-aim only while nothing is held
            if (rx_count == 0) begin
                rx_next_buf = (s == rx_expected) ? t_seq'(s + 1'b1) : s;
            end
        end else if (s != rx_expected) begin
            if (rx_count >= BUFFER_DEPTH) begin
                full_hits++;
                frame_results.push_back(make_result(K_REJECT, VALUE_NONE));
            end else begin
                for (int i = 0; i < rx_count; i++) begin
                    if (rx_store[i] == s) begin
                        dup = 1'b1;
                    end
                end
                if (!dup && rx_next_buf == s) begin
                    rx_store[rx_count] = s;
                    rx_count++;
                    rx_next_buf = s + 1'b1;
                    buffered_acks++;
                    frame_results.push_back(make_result(K_BUF_ACK, rx_last_ack));
                end else begin
                    frame_results.push_back(make_result(K_REJECT, VALUE_NONE));
                end
            end
        end else begin
            frame_results.push_back(make_result(K_DELIVER, t_value'(s)));
            for (int i = 0; i < rx_count; i++) begin
                frame_results.push_back(make_result(K_DELIVER, t_value'(rx_store[i])));
            end
            if (rx_count > 0) begin
                rx_expected = rx_store[rx_count-1];
            end
            rx_count = 0;
            frame_results.push_back(make_result(K_CUM_ACK, t_value'(rx_expected)));
            rx_last_ack = t_value'(rx_expected);
            rx_expected = rx_expected + 1'b1;
        end
        frame_results[frame_results.size()-1].last = 1'b1;
        if (frame_results.size() > longest_drain) begin
            longest_drain = frame_results.size();
        end
    endtask

    // bursts of random length with random gaps, now and then a long stretch
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                frame_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    task automatic send_frame(input t_seq s, input logic lost);
        frame_if.valid <= 1'b1;
        frame_if.seq   <= s;
        frame_if.lost  <= lost;
        do @(posedge i_clk); while (!frame_if.ready);
        frames_sent++;
        if (lost) begin
            lost_frames++;
        end
        predict_frame(s, lost);
    endtask

    task automatic hold_until_drained();
        frame_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        burst_left = $urandom_range(1, 10);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result kind %0d value %0d last %0d",
                                       result_if.kind, result_if.value, result_if.last));
            end else begin
                want = pending_results.pop_front();
                if (result_if.kind !== want.kind || result_if.value !== want.value ||
                    result_if.last !== want.last) begin
                    note_failure($sformatf(
                        "result %0d: expected kind %0d value %0d last %0d, got %0d %0d %0d",
                        results_seen, want.kind, want.value, want.last,
                        result_if.kind, result_if.value, result_if.last));
                end
            end
        end
    end

    initial begin
        t_seq s;
        logic lost;
        int   pick;

        frame_if.valid  <= 1'b0;
        frame_if.seq    <= '0;
        frame_if.lost   <= 1'b0;
        i_rst_n         <= 1'b0;

        rx_expected = '0;
        rx_next_buf = '0;
        rx_last_ack = VALUE_NONE;
        rx_count    = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            pace_sender();
            send_frame(directed_rows[r].seq, directed_rows[r].lost);
            if (directed_rows[r].known) begin
                pending_results.push_back('{directed_rows[r].kind, directed_rows[r].value,
                                            1'b1});
            end else begin
                foreach (frame_results[k]) pending_results.push_back(frame_results[k]);
            end
        end

        hold_until_drained();

        // mostly well-formed traffic around the window, some noise
        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            if (n == RANDOM_FRAMES / 2) begin
                hold_until_drained();
            end
            pick = $urandom_range(0, 99);
            lost = 1'b0;
            if (pick < 30) begin
                s = (rx_count == BUFFER_DEPTH && pick < 20) ? rx_expected : rx_next_buf;
            end else if (pick < 50) begin
                s = rx_expected;
            end else if (pick < 62) begin
                s    = rx_expected;
                lost = 1'b1;
            end else if (pick < 68) begin
                // far jump of the buffering pointer
                s    = t_seq'($urandom_range(0, 65535));
                lost = 1'b1;
            end else if (pick < 76) begin
                s = (rx_count > 0) ? rx_store[$urandom_range(0, rx_count - 1)]
                                   : t_seq'(rx_expected - 1'b1);
            end else if (pick < 84) begin
                s = rx_next_buf + t_seq'($urandom_range(1, 3));
            end else begin
                s    = t_seq'($urandom_range(0, 65535));
                lost = ($urandom_range(0, 1) == 1);
            end
            pace_sender();
            send_frame(s, lost);
            foreach (frame_results[k]) pending_results.push_back(frame_results[k]);
        end

        frame_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived",
                                   pending_results.size()));
        end

        $display("sent %0d frames (%0d lost), checked %0d results, longest drain %0d results",
                 frames_sent, lost_frames, results_seen, longest_drain);
        $display("%0d frames buffered, full reorder buffer met %0d times, %0d mismatches",
                 buffered_acks, full_hits, fail_count);
        if (fail_count == 0) begin
            $display("selective_repeat_receiver regression: pass");
        end else begin
            $display("selective_repeat_receiver regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/srr_pkg.sv
hw/rtl/srr_in_if.sv
hw/rtl/srr_out_if.sv
hw/rtl/srr_cell.sv
hw/rtl/selective_repeat_receiver.sv
test/selective_repeat_receiver_test.sv
